// ===== rtl/rtpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtpp_pkg;

    localparam int COORD_W   = 9;
    localparam int ORIGIN_W  = 9;
    localparam int SIZE_W    = 10;
    localparam int SCR_W     = 10;
    localparam int COLOR_W   = 16;
    localparam int MAX_SIZE  = 512;

    localparam int CH5_W     = 5;
    localparam int CH6_W     = 6;
    localparam logic [CH5_W-1:0] CH5_MAX = 5'h1F;
    localparam logic [CH6_W-1:0] CH6_MAX = 6'h3F;
    localparam int RED_POS   = 11;
    localparam int GRN_POS   = 5;

    // restoring divider: one quotient bit per stage, quotients below 64
    localparam int DIV_STEPS = 6;
    localparam int Q_W       = DIV_STEPS;
    localparam int DIV_W     = 15;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_SIZE     = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             hit;
        logic [SCR_W-1:0] screen_x;
        logic [SCR_W-1:0] screen_y;
        logic [DIV_W-1:0] divisor;
        logic [DIV_W-1:0] rem_g;
        logic [DIV_W-1:0] rem_r;
        logic [DIV_W-1:0] rem_b;
        logic [Q_W-1:0]   q_g;
        logic [Q_W-1:0]   q_r;
        logic [Q_W-1:0]   q_b;
    } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_triangle_pattern_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                      | item
// s_axis   | tvalid tready tdata[23:0]    | col, row
// m_axis   | tvalid tready tdata[39:0]    | color, screen_x, screen_y
// cfg      | valid ready addr[1:0] data   | register write, index in addr
//
// One item per clock while m_axis_tready is high. Stages: input stage, triangle test and
// dividends, six restoring divider stages (one quotient bit each), output pack.
// Each stage holds its own valid bit and fills any bubble while later stages
// stall. Reset clears valid bits and sets origin 0/0, size 240. cfg_ready is high.

module rgb_triangle_pattern_pixel (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // col[8:0], row[17:9], zero[23:18]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // color[15:0], screen_x[25:16],
                                            // screen_y[35:26], zero[39:36]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [9:0]  cfg_data
);
    import rtpp_pkg::*;

    // configuration
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [SIZE_W-1:0]   size_reg;
    cfg_reg_t            cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_reg_t'(cfg_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            size_reg     <= SIZE_W'(240);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_SIZE:     size_reg     <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // stage A: capture, saturate size, screen position
    logic               a_valid_reg;
    logic               a_ready;
    logic [COORD_W-1:0] a_col_reg;
    logic [COORD_W-1:0] a_row_reg;
    logic [SIZE_W-1:0]  a_size_reg;
    logic [SCR_W-1:0]   a_sx_reg;
    logic [SCR_W-1:0]   a_sy_reg;
    logic [SIZE_W-1:0]  size_sat;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;

    assign in_col = s_axis_tdata[COORD_W-1:0];
    assign in_row = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign size_sat = (32'(size_reg) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : size_reg;
    assign s_axis_tready = a_ready;

    logic b_ready;
    assign a_ready = !a_valid_reg || b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_axis_tvalid)
        begin
            a_col_reg  <= in_col;
            a_row_reg  <= in_row;
            a_size_reg <= size_sat;
            a_sx_reg   <= SCR_W'(origin_x_reg) + SCR_W'(in_col);
            a_sy_reg   <= SCR_W'(origin_y_reg) + SCR_W'(in_row);
        end
    end

    // stage B: triangle test, half offset, dividends
    logic                b_valid_reg;
    pipe_t               b_data_reg;
    pipe_t               b_data_next;
    logic [SIZE_W:0]     two_c;
    logic [SIZE_W:0]     two_c_plus_r;
    logic [SIZE_W:0]     r_plus_s;
    logic [SIZE_W-1:0]   half;
    logic [SIZE_W-1:0]   c_plus_h;
    logic [SIZE_W-1:0]   c_minus_h;
    logic                in_tri;
    logic [DIV_W-1:0]    g_div;
    logic [DIV_W-1:0]    r_div;
    logic [DIV_W-1:0]    b_div;
    logic [SIZE_W-1:0]   s_minus_r;
    logic                div_ready [DIV_STEPS+1];
    logic                div_valid [DIV_STEPS+1];
    pipe_t               div_data  [DIV_STEPS+1];

    always_comb
    begin
        two_c        = {a_col_reg, 1'b0} + (SIZE_W+1)'(0);
        two_c_plus_r = two_c + (SIZE_W+1)'(a_row_reg);
        r_plus_s     = (SIZE_W+1)'(a_row_reg) + (SIZE_W+1)'(a_size_reg);
        s_minus_r    = a_size_reg - SIZE_W'(a_row_reg);
        half         = s_minus_r >> 1;
        c_plus_h     = SIZE_W'(a_col_reg) + half;
        c_minus_h    = SIZE_W'(a_col_reg) - half;
        in_tri = (a_size_reg != '0)
              && (SIZE_W'(a_col_reg) < a_size_reg)
              && (SIZE_W'(a_row_reg) < a_size_reg)
              && (two_c_plus_r >= (SIZE_W+1)'(a_size_reg))
              && (r_plus_s >= two_c);
        g_div = (DIV_W'(a_row_reg) << CH6_W) - DIV_W'(a_row_reg);
        r_div = (DIV_W'(c_plus_h) << CH5_W) - DIV_W'(c_plus_h);
        b_div = (DIV_W'(c_minus_h) << CH5_W) - DIV_W'(c_minus_h);

        b_data_next.hit      = in_tri;
        b_data_next.screen_x = a_sx_reg;
        b_data_next.screen_y = a_sy_reg;
        b_data_next.divisor  = DIV_W'(a_size_reg) << (DIV_STEPS - 1);
        b_data_next.rem_g    = in_tri ? g_div : '0;
        b_data_next.rem_r    = in_tri ? r_div : '0;
        b_data_next.rem_b    = in_tri ? b_div : '0;
        b_data_next.q_g      = '0;
        b_data_next.q_r      = '0;
        b_data_next.q_b      = '0;
    end

    assign b_ready = !b_valid_reg || div_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    // divider stages
    assign div_valid[0] = b_valid_reg;
    assign div_data[0]  = b_data_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_stage
        rtpp_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // output stage: pack RGB565
    logic               o_valid_reg;
    logic [COLOR_W-1:0] o_color_reg;
    logic [SCR_W-1:0]   o_sx_reg;
    logic [SCR_W-1:0]   o_sy_reg;
    logic [COLOR_W-1:0] color_next;
    logic [CH5_W-1:0]   red;
    logic [CH6_W-1:0]   grn;
    logic [CH5_W-1:0]   blu;
    logic               o_ready;
    pipe_t              last;

    assign last    = div_data[DIV_STEPS];
    assign o_ready = !o_valid_reg || m_axis_tready;
    assign div_ready[DIV_STEPS] = o_ready;

    always_comb
    begin
        red = CH5_MAX - last.q_r[CH5_W-1:0];
        grn = CH6_MAX - last.q_g[CH6_W-1:0];
        blu = last.q_b[CH5_W-1:0];
        if (last.hit)
        begin
            color_next = (COLOR_W'(red) << RED_POS) | (COLOR_W'(grn) << GRN_POS)
                       | COLOR_W'(blu);
        end
        else
        begin
            color_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= div_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && div_valid[DIV_STEPS])
        begin
            o_color_reg <= color_next;
            o_sx_reg    <= last.screen_x;
            o_sy_reg    <= last.screen_y;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {4'b0, o_sy_reg, o_sx_reg, o_color_reg};

endmodule

`default_nettype wire

// ===== rtl/rtpp_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtpp_div_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rtpp_pkg::pipe_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rtpp_pkg::pipe_t     out_data
);
    import rtpp_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        if (in_data.rem_g >= in_data.divisor)
        begin
            data_next.rem_g = in_data.rem_g - in_data.divisor;
            data_next.q_g   = {in_data.q_g[Q_W-2:0], 1'b1};
        end
        else
        begin
            data_next.q_g   = {in_data.q_g[Q_W-2:0], 1'b0};
        end
        if (in_data.rem_r >= in_data.divisor)
        begin
            data_next.rem_r = in_data.rem_r - in_data.divisor;
            data_next.q_r   = {in_data.q_r[Q_W-2:0], 1'b1};
        end
        else
        begin
            data_next.q_r   = {in_data.q_r[Q_W-2:0], 1'b0};
        end
        if (in_data.rem_b >= in_data.divisor)
        begin
            data_next.rem_b = in_data.rem_b - in_data.divisor;
            data_next.q_b   = {in_data.q_b[Q_W-2:0], 1'b1};
        end
        else
        begin
            data_next.q_b   = {in_data.q_b[Q_W-2:0], 1'b0};
        end
        data_next.divisor = in_data.divisor >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
